// File: sv/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types, constants and the control store of the burst and silence
// monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned ID_BITS_DEF   = 16;

  // Field widths of the stream and configuration ports.
  localparam int REQ_W      = 2;
  localparam int MSG_ID_W   = 16;
  localparam int NOW_W      = 32;
  localparam int IN_DATA_W  = 48;
  localparam int THR_W      = 5;
  localparam int WIN_W      = 20;
  localparam int SINCE_W    = 32;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Register reset values.
  localparam logic [MSG_ID_W-1:0] TARGET_RST  = 16'd0;
  localparam logic [THR_W-1:0]    THRESH_RST  = 5'd5;
  localparam logic [WIN_W-1:0]    WINDOW_RST  = 20'd2000;
  localparam logic [WIN_W-1:0]    TIMEOUT_RST = 20'd10000;

  typedef enum logic [REQ_W-1:0] {
    REQ_MSG    = 2'd0,
    REQ_POLL   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_ID = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_WINDOW    = 2'd2,
    CFG_TIMEOUT   = 2'd3
  } cfg_idx_t;

  // Jump conditions of the sequencer.
  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_ALWAYS    = 3'd1,
    C_IN_ACC    = 3'd2,
    C_REQ_POLL  = 3'd3,
    C_REQ_CLEAR = 3'd4,
    C_NO_HIT    = 3'd5,
    C_TRIM_DONE = 3'd6,
    C_OUT_FREE  = 3'd7
  } cond_t;

  typedef logic [3:0] step_t;

  localparam step_t ST_FETCH      = 4'd0;
  localparam step_t ST_DISP_POLL  = 4'd1;
  localparam step_t ST_DISP_CLEAR = 4'd2;
  localparam step_t ST_DISP_MISS  = 4'd3;
  localparam step_t ST_PUSH       = 4'd4;
  localparam step_t ST_SETTLE     = 4'd5;
  localparam step_t ST_TRIM       = 4'd6;
  localparam step_t ST_EVAL       = 4'd7;
  localparam step_t ST_EMIT       = 4'd8;
  localparam step_t ST_CLEAR      = 4'd9;

  // Datapath strobes of one control word.
  typedef struct packed {
    logic fetch;
    logic push;
    logic pop;
    logic eval;
    logic clr;
    logic emit;
  } act_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  hold;
    act_t  act;
  } ctrl_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic in_acc;
    logic req_poll;
    logic req_clear;
    logic no_hit;
    logic trim_done;
    logic out_free;
  } status_t;

  // Control store. A taken condition jumps to target; otherwise the step
  // either holds (hold set) or falls through to the next one.
  function automatic ctrl_t rom(step_t s);
    ctrl_t w;
    w = '0;
    unique case (s)
      ST_FETCH: begin
        w.cond = C_IN_ACC; w.target = ST_DISP_POLL; w.hold = 1'b1;
        w.act.fetch = 1'b1;
      end
      ST_DISP_POLL: begin
        w.cond = C_REQ_POLL; w.target = ST_TRIM;
      end
      ST_DISP_CLEAR: begin
        w.cond = C_REQ_CLEAR; w.target = ST_CLEAR;
      end
      ST_DISP_MISS: begin
        w.cond = C_NO_HIT; w.target = ST_EMIT;
      end
      ST_PUSH: begin
        w.cond = C_NEVER; w.target = ST_FETCH;
        w.act.push = 1'b1;
      end
      ST_SETTLE: begin
        w.cond = C_NEVER; w.target = ST_FETCH;
      end
      ST_TRIM: begin
        w.cond = C_TRIM_DONE; w.target = ST_EVAL; w.hold = 1'b1;
        w.act.pop = 1'b1;
      end
      ST_EVAL: begin
        w.cond = C_ALWAYS; w.target = ST_EMIT;
        w.act.eval = 1'b1;
      end
      ST_EMIT: begin
        w.cond = C_OUT_FREE; w.target = ST_FETCH; w.hold = 1'b1;
        w.act.emit = 1'b1;
      end
      ST_CLEAR: begin
        w.cond = C_ALWAYS; w.target = ST_EMIT;
        w.act.clr = 1'b1;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = ST_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: sv/burst_and_silence_monitor_core.sv
// ----------------------------------------------------------------------------
// burst_and_silence_monitor_core
// Counts target messages in a sliding time window and raises one-shot burst
// and silence flags, under control of a small microcoded sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  in_      slave      tuser: req_type; tdata: msg_id, now_ms
//  out_     master     tdata: burst_detected, burst_count, silence_detected,
//                      since_last_ms (one result beat per input beat)
//  cfg_     slave      cfg_index selects the register, cfg_data the value
//
// A target message is pushed, trimmed, evaluated and emitted; a poll is trimmed,
// evaluated and emitted; a clear empties the state, then emits; others only emit.
// The trim loop pops at most DEPTH stamps, one per cycle, as the ring has one
// read port whose data is registered.
// Reset is synchronous and needs no clearing pass: the ring is read only
// below the fill count. A stalled result holds the sequencer in its emit step.
// ----------------------------------------------------------------------------
`default_nettype none

module burst_and_silence_monitor_core #(
  parameter int unsigned DEPTH     = bsm_pkg::DEPTH_DEF,
  parameter int unsigned TIME_BITS = bsm_pkg::TIME_BITS_DEF,
  parameter int unsigned ID_BITS   = bsm_pkg::ID_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [15:0] msg_id, [47:16] now_ms
  input  wire logic [bsm_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] req_type
  input  wire logic [bsm_pkg::REQ_W-1:0]       in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [0] burst_detected, [5:1] burst_count, [6] silence_detected,
  // [38:7] since_last_ms, [39] zero
  output logic [bsm_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bsm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int TW     = TIME_BITS;
  localparam int CW     = (TW > bsm_pkg::WIN_W) ? TW : bsm_pkg::WIN_W;
  localparam int KW     = (CNT_W > bsm_pkg::THR_W) ? CNT_W : bsm_pkg::THR_W;
  localparam int ID_CMP = (ID_BITS < bsm_pkg::MSG_ID_W) ? ID_BITS : bsm_pkg::MSG_ID_W;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
  localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(DEPTH);

  // Configuration registers.
  logic [bsm_pkg::MSG_ID_W-1:0] target_r;
  logic [bsm_pkg::THR_W-1:0]    thresh_r;
  logic [bsm_pkg::WIN_W-1:0]    window_r;
  logic [bsm_pkg::WIN_W-1:0]    timeout_r;

  // Latched item.
  logic [bsm_pkg::REQ_W-1:0]    req_r;
  logic [bsm_pkg::MSG_ID_W-1:0] id_r;
  logic [TW-1:0]                now_r;

  // Monitor state.
  logic [IDX_W-1:0] oldest_r, oldest_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [TW-1:0]    last_seen_r, last_seen_nxt;
  logic             burst_off_r, burst_off_nxt;
  logic             sil_off_r, sil_off_nxt;

  // Result being built and the output register.
  logic                        res_burst_r, res_burst_nxt;
  logic [bsm_pkg::THR_W-1:0]   res_cnt_r, res_cnt_nxt;
  logic                        res_sil_r, res_sil_nxt;
  logic [bsm_pkg::SINCE_W-1:0] res_since_r, res_since_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [bsm_pkg::OUT_DATA_W-1:0] out_data_r;

  // Stamp ring.
  logic [TW-1:0]    ring [DEPTH];
  logic [TW-1:0]    rd_data_r;
  logic             wr_en;
  logic [IDX_W-1:0] wr_slot;

  bsm_pkg::status_t status;
  bsm_pkg::act_t    act;

  logic             in_acc;
  logic             hit;
  logic             out_free;
  logic             trim_done;
  logic             emit_fire;
  logic [TW-1:0]    age;
  logic [TW-1:0]    since;
  logic             burst_ge;
  logic             since_ge;
  logic             full;
  logic [IDX_W-1:0] push_oldest;
  logic [IDX_W-1:0] push_base;
  logic [IDX_W:0]   slot_sum;

  assign cfg_ready = 1'b1;
  assign in_tready = act.fetch;
  assign in_acc    = in_tvalid && act.fetch;

  assign hit = (req_r == bsm_pkg::REQ_MSG) && (id_r[ID_CMP-1:0] == target_r[ID_CMP-1:0]);
  assign age = now_r - rd_data_r;
  assign trim_done = (count_r == '0) || (CW'(age) <= CW'(window_r));
  assign since = now_r - last_seen_r;
  assign burst_ge = KW'(count_r) >= KW'(thresh_r);
  assign since_ge = CW'(since) >= CW'(timeout_r);
  assign out_free = !out_valid_r || out_tready;
  assign emit_fire = act.emit && out_free;

  assign status.in_acc    = in_acc;
  assign status.req_poll  = (req_r == bsm_pkg::REQ_POLL);
  assign status.req_clear = (req_r == bsm_pkg::REQ_CLEAR);
  assign status.no_hit    = !hit;
  assign status.trim_done = trim_done;
  assign status.out_free  = out_free;

  bsm_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .act    (act)
  );

  // A full ring drops its oldest stamp before the new one goes in.
  assign full        = (count_r == FULL_CNT);
  assign push_oldest = full ? ((oldest_r == LAST_IDX) ? '0 : oldest_r + 1'b1) : oldest_r;
  assign push_base   = full ? LAST_IDX : count_r[IDX_W-1:0];
  assign slot_sum    = (IDX_W + 1)'(push_oldest) + (IDX_W + 1)'(push_base);
  assign wr_slot     = (slot_sum >= DEPTH_EXT) ? IDX_W'(slot_sum - DEPTH_EXT)
                                               : slot_sum[IDX_W-1:0];
  assign wr_en       = act.push;

  always_comb begin
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    last_seen_nxt = last_seen_r;
    burst_off_nxt = burst_off_r;
    sil_off_nxt   = sil_off_r;
    res_burst_nxt = res_burst_r;
    res_cnt_nxt   = res_cnt_r;
    res_sil_nxt   = res_sil_r;
    res_since_nxt = res_since_r;

    if (in_acc) begin
      res_burst_nxt = 1'b0;
      res_cnt_nxt   = '0;
      res_sil_nxt   = 1'b0;
      res_since_nxt = '0;
    end

    if (act.push) begin
      oldest_nxt    = push_oldest;
      count_nxt     = CNT_W'(push_base) + 1'b1;
      last_seen_nxt = now_r;
      sil_off_nxt   = 1'b0;
    end

    if (act.pop && !trim_done) begin
      oldest_nxt = (oldest_r == LAST_IDX) ? '0 : oldest_r + 1'b1;
      count_nxt  = count_r - 1'b1;
    end

    if (act.eval) begin
      if (req_r == bsm_pkg::REQ_MSG) begin
        if (!burst_ge) begin
          burst_off_nxt = 1'b0;
        end else if (!burst_off_r) begin
          burst_off_nxt = 1'b1;
          res_burst_nxt = 1'b1;
          res_cnt_nxt   = bsm_pkg::THR_W'(count_r);
        end
      end else if (since_ge && !sil_off_r) begin
        sil_off_nxt   = 1'b1;
        res_sil_nxt   = 1'b1;
        res_since_nxt = bsm_pkg::SINCE_W'(since);
      end
    end

    if (act.clr) begin
      oldest_nxt    = '0;
      count_nxt     = '0;
      burst_off_nxt = 1'b0;
      sil_off_nxt   = 1'b0;
      last_seen_nxt = now_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= bsm_pkg::TARGET_RST;
      thresh_r    <= bsm_pkg::THRESH_RST;
      window_r    <= bsm_pkg::WINDOW_RST;
      timeout_r   <= bsm_pkg::TIMEOUT_RST;
      oldest_r    <= '0;
      count_r     <= '0;
      last_seen_r <= '0;
      burst_off_r <= 1'b0;
      sil_off_r   <= 1'b0;
      res_burst_r <= 1'b0;
      res_sil_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          bsm_pkg::CFG_TARGET_ID: target_r  <= cfg_data[bsm_pkg::MSG_ID_W-1:0];
          bsm_pkg::CFG_THRESHOLD: thresh_r  <= cfg_data[bsm_pkg::THR_W-1:0];
          bsm_pkg::CFG_WINDOW:    window_r  <= cfg_data;
          bsm_pkg::CFG_TIMEOUT:   timeout_r <= cfg_data;
          default: ;
        endcase
      end
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      last_seen_r <= last_seen_nxt;
      burst_off_r <= burst_off_nxt;
      sil_off_r   <= sil_off_nxt;
      res_burst_r <= res_burst_nxt;
      res_sil_r   <= res_sil_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_cnt_r   <= res_cnt_nxt;
    res_since_r <= res_since_nxt;
    if (in_acc) begin
      req_r <= in_tuser;
      id_r  <= in_tdata[15:0];
      now_r <= TW'(in_tdata[47:16]);
    end
    if (emit_fire) begin
      out_data_r <= {1'b0, res_since_r, res_sil_r, res_cnt_r, res_burst_r};
    end
  end

  // The read port follows the next oldest index, so the head stamp is ready
  // in the cycle after a pop. The settle step after a push covers the case
  // where the write lands on the head slot.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_slot] <= now_r;
    end
    rd_data_r <= ring[oldest_nxt];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("stamp count above ring depth");

  a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (IDX_W + 1)'(oldest_r) < DEPTH_EXT)
    else $error("oldest index outside ring");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[0] && out_data_r[6]))
    else $error("burst and silence flagged in one beat");

  a_quiet_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r[0]) |-> (out_data_r[5:1] == '0))
    else $error("burst count without burst flag");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    act.clr |=> (count_r == '0) && !burst_off_r && !sil_off_r)
    else $error("clear left state behind");
`endif

endmodule

`default_nettype wire

// File: sv/bsm_seq.sv
// ----------------------------------------------------------------------------
// bsm_seq
// Microcode sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bsm_pkg::status_t status,
  output bsm_pkg::act_t         act
);

  bsm_pkg::step_t pc_r;
  bsm_pkg::step_t pc_nxt;
  bsm_pkg::ctrl_t word;
  logic           take;

  assign word = bsm_pkg::rom(pc_r);
  assign act  = word.act;

  always_comb begin
    unique case (word.cond)
      bsm_pkg::C_NEVER:     take = 1'b0;
      bsm_pkg::C_ALWAYS:    take = 1'b1;
      bsm_pkg::C_IN_ACC:    take = status.in_acc;
      bsm_pkg::C_REQ_POLL:  take = status.req_poll;
      bsm_pkg::C_REQ_CLEAR: take = status.req_clear;
      bsm_pkg::C_NO_HIT:    take = status.no_hit;
      bsm_pkg::C_TRIM_DONE: take = status.trim_done;
      bsm_pkg::C_OUT_FREE:  take = status.out_free;
      default:              take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_nxt = word.target;
    end else if (word.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= bsm_pkg::ST_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire
